// ===== sv/prx_pkg.sv =====
// ----------------------------------------------------------------------------
// prx_pkg
// Shared types and constants for the row-to-RGBA pixel expander.
// ----------------------------------------------------------------------------
package prx_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int PAL_DW          = 32;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [2:0] MODE_GRAY       = 3'd0;
    localparam logic [2:0] MODE_RGB        = 3'd1;
    localparam logic [2:0] MODE_PALETTE    = 3'd2;
    localparam logic [2:0] MODE_GRAY_ALPHA = 3'd3;
    localparam logic [2:0] MODE_RGBA8      = 3'd4;

    localparam logic [2:0] DEPTH_1  = 3'd0;
    localparam logic [2:0] DEPTH_2  = 3'd1;
    localparam logic [2:0] DEPTH_4  = 3'd2;
    localparam logic [2:0] DEPTH_8  = 3'd3;
    localparam logic [2:0] DEPTH_16 = 3'd4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    localparam logic [1:0] REG_COLOR_MODE  = 2'd0;
    localparam logic [1:0] REG_DEPTH_CODE  = 2'd1;
    localparam logic [1:0] REG_ROW_PIXELS  = 2'd2;
    localparam logic [1:0] REG_TRANS_COUNT = 2'd3;

    localparam logic [2:0]  RST_COLOR_MODE  = MODE_PALETTE;
    localparam logic [2:0]  RST_DEPTH_CODE  = DEPTH_8;
    localparam logic [12:0] RST_ROW_PIXELS  = 13'd1;
    localparam logic [8:0]  RST_TRANS_COUNT = 9'd0;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       row_end;
        logic [7:0] entry_index;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
        logic [7:0] entry_alpha;
    } src_item_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic        wide_channels;
        logic        row_last;
        logic        batch_last;
    } pix_item_t;

    typedef struct packed {
        logic [2:0]  color_mode;
        logic [2:0]  depth_code;
        logic [12:0] row_pixels;
        logic [8:0]  trans_count;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [PAL_AW-1:0] addr;
        logic [PAL_DW-1:0] data;
    } pal_wr_t;

    // one pixel in flight between issue and output queue
    typedef struct packed {
        logic        pal;
        logic        pal_hit;
        logic        use_alpha;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic        wide;
        logic        row_last;
        logic        batch_last;
    } slot_t;

endpackage

// ===== sv/prx_ram.sv =====
// ----------------------------------------------------------------------------
// prx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/prx_issue.sv =====
// ----------------------------------------------------------------------------
// prx_issue
// Request intake, row state, palette index sequencer and sample assembly.
// Issues at most one pixel per cycle into a registered slot aligned with the
// palette read.
// ----------------------------------------------------------------------------
module prx_issue
    import prx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               src_valid,
    output logic               src_ready,
    input  src_item_t          src,
    input  logic [OUTQ_CW-1:0] outq_count,
    output pal_wr_t            pal_wr,
    output logic [PAL_AW-1:0]  pal_raddr,
    output logic               slot_valid,
    output slot_t              slot
);

    logic        seq_active_reg, seq_active_next;
    logic [7:0]  seq_byte_reg, seq_byte_next;
    logic [2:0]  seq_sub_reg, seq_sub_next;
    logic        seq_rend_reg, seq_rend_next;
    logic [12:0] done_reg, done_next;
    logic [2:0]  phase_reg, phase_next;
    logic [39:0] partial_reg, partial_next;
    logic        slot_valid_reg, slot_valid_next;
    slot_t       slot_reg, slot_next;

    logic        credit_ok;
    logic        accept;
    logic        data_acc;
    logic        pal_mode;
    logic [7:0]  cur_byte;
    logic [2:0]  cur_sub;
    logic        cur_rend;
    logic [2:0]  shamt;
    logic [7:0]  shifted;
    logic [7:0]  idx;
    logic [2:0]  sub_max;
    logic        pal_go;
    logic        emit_ok;
    logic        row_full;
    logic        last_sub;
    logic        blast;
    logic        pal_emit;
    logic        pal_end;
    logic [2:0]  size;
    logic        complete;
    logic        np_emit;
    logic        wide;
    logic [47:0] v;
    logic [7:0]  b [6];
    logic [15:0] c0, c1, c2, c3, op;
    logic [15:0] nr, ng, nb, na;

    function automatic logic [7:0] pick(input logic [47:0] val, input logic [2:0] pos);
        logic [7:0] r;
        begin
            case (pos)
                3'd0:    r = val[7:0];
                3'd1:    r = val[15:8];
                3'd2:    r = val[23:16];
                3'd3:    r = val[31:24];
                3'd4:    r = val[39:32];
                3'd5:    r = val[47:40];
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    assign credit_ok = ({1'b0, outq_count} + (OUTQ_CW+1)'(slot_valid_reg))
                       < (OUTQ_CW+1)'(OUTQ_DEPTH);
    assign src_ready = !seq_active_reg && credit_ok;
    assign accept    = src_valid && src_ready;
    assign data_acc  = accept && (src.command == CMD_DATA);
    assign pal_mode  = (cfg.color_mode == MODE_PALETTE) && (cfg.depth_code <= DEPTH_8);

    assign pal_wr.we   = accept && (src.command == CMD_LOAD)
                         && (32'(src.entry_index) < PALETTE_ENTRIES);
    assign pal_wr.addr = src.entry_index[PAL_AW-1:0];
    assign pal_wr.data = {src.entry_red, src.entry_green, src.entry_blue, src.entry_alpha};

    // palette index extraction, MSB first
    always_comb
    begin
        cur_byte = seq_active_reg ? seq_byte_reg : src.data_byte;
        cur_sub  = seq_active_reg ? seq_sub_reg : 3'd0;
        cur_rend = seq_active_reg ? seq_rend_reg : src.row_end;
        shamt    = cur_sub << cfg.depth_code[1:0];
        shifted  = cur_byte << shamt;
        unique case (cfg.depth_code[1:0])
            2'd0:
            begin
                idx     = {7'd0, shifted[7]};
                sub_max = 3'd7;
            end
            2'd1:
            begin
                idx     = {6'd0, shifted[7:6]};
                sub_max = 3'd3;
            end
            2'd2:
            begin
                idx     = {4'd0, shifted[7:4]};
                sub_max = 3'd1;
            end
            default:
            begin
                idx     = shifted;
                sub_max = 3'd0;
            end
        endcase
    end

    assign pal_raddr = idx[PAL_AW-1:0];
    assign pal_go    = seq_active_reg ? credit_ok : (data_acc && pal_mode);
    assign emit_ok   = done_reg < cfg.row_pixels;
    assign row_full  = ({1'b0, done_reg} + 14'd1) == {1'b0, cfg.row_pixels};
    assign last_sub  = cur_sub == sub_max;
    assign blast     = last_sub || row_full;
    assign pal_emit  = pal_go && emit_ok;
    assign pal_end   = pal_go && (!emit_ok || blast);

    // byte-oriented formats
    always_comb
    begin
        size = 3'd0;
        case (cfg.color_mode)
            MODE_RGBA8:      size = 3'd4;
            MODE_GRAY:       size = (cfg.depth_code == DEPTH_16) ? 3'd2 : 3'd1;
            MODE_RGB:        size = (cfg.depth_code == DEPTH_16) ? 3'd6 : 3'd3;
            MODE_GRAY_ALPHA: size = (cfg.depth_code == DEPTH_16) ? 3'd4 : 3'd2;
            default:         size = 3'd0;
        endcase
        if (cfg.color_mode != MODE_RGBA8 && cfg.depth_code != DEPTH_8
            && cfg.depth_code != DEPTH_16)
        begin
            size = 3'd0;
        end
    end

    assign complete = (size != 3'd0) && (({1'b0, phase_reg} + 4'd1) >= {1'b0, size});
    assign np_emit  = data_acc && !pal_mode && complete && emit_ok;
    assign wide     = (cfg.color_mode != MODE_RGBA8) && (cfg.depth_code == DEPTH_16);
    assign v        = {partial_reg, src.data_byte};

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            b[k] = pick(v, size - 3'd1 - 3'(k));
        end
        c0 = wide ? {b[0], b[1]} : {8'h00, b[0]};
        c1 = wide ? {b[2], b[3]} : {8'h00, b[1]};
        c2 = wide ? {b[4], b[5]} : {8'h00, b[2]};
        c3 = {8'h00, b[3]};
        op = wide ? 16'hFFFF : 16'h00FF;
        case (cfg.color_mode)
            MODE_GRAY:
            begin
                nr = c0; ng = c0; nb = c0; na = op;
            end
            MODE_RGB:
            begin
                nr = c0; ng = c1; nb = c2; na = op;
            end
            MODE_GRAY_ALPHA:
            begin
                nr = c0; ng = c0; nb = c0; na = c1;
            end
            default:
            begin
                nr = c0; ng = c1; nb = c2; na = c3;
            end
        endcase
    end

    always_comb
    begin
        slot_next            = slot_reg;
        slot_valid_next      = pal_emit || np_emit;
        if (pal_emit)
        begin
            slot_next.pal        = 1'b1;
            slot_next.pal_hit    = 32'(idx) < PALETTE_ENTRIES;
            slot_next.use_alpha  = {1'b0, idx} < cfg.trans_count;
            slot_next.red        = 16'h0000;
            slot_next.green      = 16'h0000;
            slot_next.blue       = 16'h0000;
            slot_next.alpha      = 16'h0000;
            slot_next.wide       = 1'b0;
            slot_next.row_last   = row_full || (cur_rend && blast);
            slot_next.batch_last = blast;
        end
        else if (np_emit)
        begin
            slot_next.pal        = 1'b0;
            slot_next.pal_hit    = 1'b0;
            slot_next.use_alpha  = 1'b0;
            slot_next.red        = nr;
            slot_next.green      = ng;
            slot_next.blue       = nb;
            slot_next.alpha      = na;
            slot_next.wide       = wide;
            slot_next.row_last   = row_full || src.row_end;
            slot_next.batch_last = 1'b1;
        end
    end

    always_comb
    begin
        seq_active_next = seq_active_reg;
        seq_byte_next   = seq_byte_reg;
        seq_sub_next    = seq_sub_reg;
        seq_rend_next   = seq_rend_reg;
        done_next       = done_reg;
        phase_next      = phase_reg;
        partial_next    = partial_reg;

        if (pal_go)
        begin
            if (pal_end)
            begin
                seq_active_next = 1'b0;
            end
            else
            begin
                seq_active_next = 1'b1;
                seq_byte_next   = cur_byte;
                seq_rend_next   = cur_rend;
                seq_sub_next    = cur_sub + 3'd1;
            end
        end

        if (pal_emit || np_emit)
        begin
            done_next = done_reg + 13'd1;
        end
        if ((pal_end && cur_rend) || (data_acc && !pal_mode && src.row_end))
        begin
            done_next = 13'd0;
        end

        if (data_acc && !pal_mode && size != 3'd0)
        begin
            if (complete)
            begin
                phase_next   = 3'd0;
                partial_next = 40'd0;
            end
            else
            begin
                phase_next   = phase_reg + 3'd1;
                partial_next = {partial_reg[31:0], src.data_byte};
            end
        end
        if (data_acc && src.row_end)
        begin
            phase_next   = 3'd0;
            partial_next = 40'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_active_reg <= 1'b0;
            seq_rend_reg   <= 1'b0;
            seq_sub_reg    <= 3'd0;
            done_reg       <= 13'd0;
            phase_reg      <= 3'd0;
            partial_reg    <= 40'd0;
            slot_valid_reg <= 1'b0;
        end
        else
        begin
            seq_active_reg <= seq_active_next;
            seq_rend_reg   <= seq_rend_next;
            seq_sub_reg    <= seq_sub_next;
            done_reg       <= done_next;
            phase_reg      <= phase_next;
            partial_reg    <= partial_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_byte_reg <= seq_byte_next;
        slot_reg     <= slot_next;
    end

    assign slot_valid = slot_valid_reg;
    assign slot       = slot_reg;

    // sequencer only runs for sub-byte palette indices
    a_seq_mode: assert property (@(posedge clk) disable iff (!rst_n)
        seq_active_reg |-> (cfg.color_mode == MODE_PALETTE) && (cfg.depth_code < DEPTH_8))
        else $error("sequencer active outside sub-byte palette mode");

    // byte formats give at most one pixel per request, so it always closes the batch
    a_np_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_valid_reg && !slot_reg.pal) |-> slot_reg.batch_last)
        else $error("byte-format pixel without batch_last");

    // no request is taken while sub-pixels of a byte are still pending
    a_seq_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_active_reg && !pal_end) |=> seq_active_reg && $stable(seq_byte_reg))
        else $error("held palette byte lost");

endmodule

// ===== sv/prx_outq.sv =====
// ----------------------------------------------------------------------------
// prx_outq
// Merges palette read data into issued slots and buffers finished pixels.
// ----------------------------------------------------------------------------
module prx_outq
    import prx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               slot_valid,
    input  slot_t              slot,
    input  logic [PAL_DW-1:0]  pal_rdata,
    output logic [OUTQ_CW-1:0] count,
    output logic               pix_valid,
    input  logic               pix_ready,
    output pix_item_t          pix
);

    pix_item_t          q_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] head_reg, head_next;
    logic [OUTQ_AW-1:0] tail_reg, tail_next;
    logic [OUTQ_CW-1:0] count_reg, count_next;
    logic               pop;
    logic [31:0]        ent;
    pix_item_t          fresh;

    always_comb
    begin
        ent = slot.pal_hit ? pal_rdata : 32'd0;
        if (slot.pal)
        begin
            fresh.red   = {8'h00, ent[31:24]};
            fresh.green = {8'h00, ent[23:16]};
            fresh.blue  = {8'h00, ent[15:8]};
            fresh.alpha = slot.use_alpha ? {8'h00, ent[7:0]} : 16'h00FF;
        end
        else
        begin
            fresh.red   = slot.red;
            fresh.green = slot.green;
            fresh.blue  = slot.blue;
            fresh.alpha = slot.alpha;
        end
        fresh.wide_channels = slot.wide;
        fresh.row_last      = slot.row_last;
        fresh.batch_last    = slot.batch_last;
    end

    assign pop       = pix_valid && pix_ready;
    assign pix_valid = count_reg != '0;
    assign pix       = q_mem[head_reg];
    assign count     = count_reg;

    always_comb
    begin
        head_next  = pop ? head_reg + OUTQ_AW'(1) : head_reg;
        tail_next  = slot_valid ? tail_reg + OUTQ_AW'(1) : tail_reg;
        count_next = count_reg + OUTQ_CW'(slot_valid) - OUTQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_valid)
        begin
            q_mem[tail_reg] <= fresh;
        end
    end

    // credit check upstream keeps the queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        slot_valid |-> (count_reg < OUTQ_CW'(OUTQ_DEPTH)) || pop)
        else $error("pixel queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OUTQ_CW'(OUTQ_DEPTH))
        else $error("pixel queue count out of range");

endmodule

// ===== sv/png_row_expand_to_rgba.sv =====
// ----------------------------------------------------------------------------
// png_row_expand_to_rgba
// Expands raw image row bytes into RGBA pixels, with palette lookup through
// a 256-entry palette RAM and an APB register port for the row format.
// ----------------------------------------------------------------------------
// Path: a taken request is registered in the issue slot along with its palette
// read, then written into the output queue, from which pix presents it.
// Throughput: one request per cycle for 8/16-bit formats and loads while pix is
// drained; a byte of 1, 2 or 4 bit palette indices (one RAM read per pixel) holds
// src_ready low until its last index or the row's last pixel, longer if pix stalls.
// Reset: registers return to palette/8-bit/1 pixel/no transparency, row state
// clears; palette contents stay undefined until loaded.
module png_row_expand_to_rgba
    import prx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              src_valid,
    output logic              src_ready,
    input  src_item_t         src,
    output logic              pix_valid,
    input  logic              pix_ready,
    output pix_item_t         pix
);

    cfg_t               cfg_reg, cfg_next;
    logic               cfg_wr;
    pal_wr_t            pal_wr;
    logic [PAL_AW-1:0]  pal_raddr;
    logic [PAL_DW-1:0]  pal_rdata;
    logic               slot_valid;
    slot_t              slot;
    logic [OUTQ_CW-1:0] outq_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_COLOR_MODE:  cfg_next.color_mode  = pwdata[2:0];
                REG_DEPTH_CODE:  cfg_next.depth_code  = pwdata[2:0];
                REG_ROW_PIXELS:  cfg_next.row_pixels  = pwdata[12:0];
                REG_TRANS_COUNT: cfg_next.trans_count = pwdata[8:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_COLOR_MODE:  prdata = {29'd0, cfg_reg.color_mode};
            REG_DEPTH_CODE:  prdata = {29'd0, cfg_reg.depth_code};
            REG_ROW_PIXELS:  prdata = {19'd0, cfg_reg.row_pixels};
            REG_TRANS_COUNT: prdata = {23'd0, cfg_reg.trans_count};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_mode  <= RST_COLOR_MODE;
            cfg_reg.depth_code  <= RST_DEPTH_CODE;
            cfg_reg.row_pixels  <= RST_ROW_PIXELS;
            cfg_reg.trans_count <= RST_TRANS_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    prx_issue u_issue (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .src        (src),
        .outq_count (outq_count),
        .pal_wr     (pal_wr),
        .pal_raddr  (pal_raddr),
        .slot_valid (slot_valid),
        .slot       (slot)
    );

    prx_ram #(
        .WIDTH (PAL_DW),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (pal_wr.we),
        .waddr (pal_wr.addr),
        .wdata (pal_wr.data),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    prx_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_valid (slot_valid),
        .slot       (slot),
        .pal_rdata  (pal_rdata),
        .count      (outq_count),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix        (pix)
    );

endmodule
